@@ sv/scpa_pkg.sv @@
// Shared constants for the parabolic sine and cosine approximation pipeline.
package scpa_pkg;

    // Pi with 60 fraction bits; the angle-format multiples of pi are rounded from this.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Fraction bits of the working angle and of the coefficients.
    localparam int WORK_FRAC = 28;
    localparam int COEF_FRAC = 30;

    // Width of the unsigned value that the range reduction works on.
    localparam int RED_W = 36;

    // Width of the intermediate products after truncation.
    localparam int VAL_W = 34;

    // Coefficients with 30 fraction bits: 4/pi, 4/pi^2 and 0.225.
    localparam logic signed [31:0] COEF_B = 32'sd1367130551;
    localparam logic signed [31:0] COEF_C = 32'sd435171170;
    localparam logic signed [31:0] COEF_P = 32'sd241591910;

endpackage

@@ sv/sine_cosine_parabolic_approx.sv @@
// Pipelined parabolic sine and cosine approximation with floored range reduction.
// Throughput is one item per cycle while i_stall is low. The range reduction has NSTEP
// stages, NSTEP = 36 - clog2(round(2*pi * 2^ANGLE_FRAC_BITS)), each doing one compare and
// subtract of a shifted 2*pi; four stages with five multiplies form the parabola and refinement.
// Reset is synchronous and clears only the stage valid bits; data registers are not reset.
module sine_cosine_parabolic_approx #(
    parameter int ANGLE_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value
);

    localparam int UW = scpa_pkg::RED_W;
    localparam int VW = scpa_pkg::VAL_W;

    localparam logic [63:0] PI_A =
        (scpa_pkg::PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] TWO_PI_A =
        (scpa_pkg::PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI_A =
        (scpa_pkg::PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);

    localparam int MOD_BITS = $clog2(TWO_PI_A);
    localparam int SH       = 34 - MOD_BITS;
    localparam int NSTEP    = SH + 2;
    localparam int XSHIFT   = scpa_pkg::WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int OSHIFT   = scpa_pkg::COEF_FRAC - RESULT_FRAC_BITS;

    // A multiple of 2*pi is added so the reduction only sees nonnegative values.
    localparam logic [UW-1:0] ADD_SIN = UW'(PI_A + (TWO_PI_A << SH));
    localparam logic [UW-1:0] ADD_COS = UW'(PI_A + HALF_PI_A + (TWO_PI_A << SH));
    localparam logic [UW-1:0] PI_U    = UW'(PI_A);
    localparam logic [UW-1:0] MOD_U   = UW'(TWO_PI_A);
    localparam logic [31:0]   X_MAX   = 32'((PI_A + 64'd1) << XSHIFT);

    localparam logic signed [VW:0] SAT_MAX = (VW + 1)'(64'sd2147483647);
    localparam logic signed [VW:0] SAT_MIN = (VW + 1)'(-64'sd2147483648);

    // Stage indexes after the reduction chain.
    localparam int SX  = NSTEP + 1;
    localparam int SM1 = NSTEP + 2;
    localparam int SM2 = NSTEP + 3;
    localparam int SY  = NSTEP + 4;
    localparam int SYY = NSTEP + 5;
    localparam int SD  = NSTEP + 6;
    localparam int SP  = NSTEP + 7;
    localparam int SO  = NSTEP + 8;
    localparam int NS  = NSTEP + 9;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_rdy;
    logic [NS-1:0] w_up;

    logic [UW-1:0] r_red [0:NSTEP];
    logic [UW-1:0] w_u0;

    logic signed [UW-1:0] w_xa;
    logic signed [UW-1:0] w_xn;
    logic signed [UW-1:0] w_xabs;
    logic signed [31:0]   r_x;
    logic signed [31:0]   r_ax;

    logic signed [63:0]   w_pb;
    logic signed [63:0]   w_pxx;
    logic signed [VW-1:0] r_bx;
    logic signed [VW-1:0] r_xx;

    logic signed [63:0]   w_pc;
    logic signed [VW-1:0] r_cx;
    logic signed [VW-1:0] r_bx2;

    logic signed [VW-1:0] w_y;
    logic signed [VW-1:0] w_yn;
    logic signed [VW-1:0] r_y;
    logic signed [VW-1:0] r_ay;

    logic signed [63:0]   w_pyy;
    logic signed [VW-1:0] r_yy;
    logic signed [VW-1:0] r_y2;

    logic signed [VW-1:0] r_d;
    logic signed [VW-1:0] r_y3;

    logic signed [63:0]   w_pp;
    logic signed [VW-1:0] r_pd;
    logic signed [VW-1:0] r_y4;

    logic signed [VW:0]   w_sum;
    logic signed [VW:0]   w_sh;
    logic signed [31:0]   n_value;
    logic signed [31:0]   r_value;

    // A stage takes new data when it is empty or the stage after it moves on.
    assign w_rdy[NS-1] = !r_vld[NS-1] || !i_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign w_up  = {r_vld[NS-2:0], i_valid};
    assign n_vld = (w_rdy & w_up) | (~w_rdy & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_value = r_value;

    // Entry: angle plus pi (and pi/2 for cosine) plus the offset.
    assign w_u0 = UW'(i_angle) + (i_func ? ADD_COS : ADD_SIN);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_red[0] <= w_u0;
        end
    end

    // Restoring reduction: one shifted copy of 2*pi is tried in each stage.
    for (genvar j = 0; j < NSTEP; j++) begin : g_red
        localparam logic [UW-1:0] MK = UW'(TWO_PI_A << (SH + 1 - j));
        logic [UW-1:0] n_red;

        assign n_red = (r_red[j] >= MK) ? (r_red[j] - MK) : r_red[j];

        always_ff @(posedge i_clk) begin
            if (w_rdy[j+1]) begin
                r_red[j+1] <= n_red;
            end
        end
    end

    assign w_xa   = $signed(r_red[NSTEP] - PI_U);
    assign w_xn   = $signed(PI_U - r_red[NSTEP]);
    assign w_xabs = w_xa[UW-1] ? w_xn : w_xa;

    assign w_pb  = 64'(r_x) * 64'(scpa_pkg::COEF_B);
    assign w_pxx = 64'(r_x) * 64'(r_ax);
    assign w_pc  = 64'(r_xx) * 64'(scpa_pkg::COEF_C);
    assign w_y   = r_bx2 - r_cx;
    assign w_yn  = r_cx - r_bx2;
    assign w_pyy = 64'(r_y) * 64'(r_ay);
    assign w_pp  = 64'(r_d) * 64'(scpa_pkg::COEF_P);

    assign w_sum = (VW + 1)'(r_pd) + (VW + 1)'(r_y4);
    assign w_sh  = w_sum >>> OSHIFT;

    always_comb begin
        if (w_sh > SAT_MAX) begin
            n_value = 32'sh7FFFFFFF;
        end else if (w_sh < SAT_MIN) begin
            n_value = 32'sh80000000;
        end else begin
            n_value = w_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[SX]) begin
            r_x  <= 32'(w_xa <<< XSHIFT);
            r_ax <= 32'(w_xabs <<< XSHIFT);
        end
        if (w_rdy[SM1]) begin
            r_bx <= w_pb[scpa_pkg::WORK_FRAC +: VW];
            r_xx <= w_pxx[scpa_pkg::WORK_FRAC +: VW];
        end
        if (w_rdy[SM2]) begin
            r_cx  <= w_pc[scpa_pkg::WORK_FRAC +: VW];
            r_bx2 <= r_bx;
        end
        if (w_rdy[SY]) begin
            r_y  <= w_y;
            r_ay <= w_y[VW-1] ? w_yn : w_y;
        end
        if (w_rdy[SYY]) begin
            r_yy <= w_pyy[scpa_pkg::COEF_FRAC +: VW];
            r_y2 <= r_y;
        end
        if (w_rdy[SD]) begin
            r_d  <= r_yy - r_y2;
            r_y3 <= r_y2;
        end
        if (w_rdy[SP]) begin
            r_pd <= w_pp[scpa_pkg::COEF_FRAC +: VW];
            r_y4 <= r_y3;
        end
        if (w_rdy[SO]) begin
            r_value <= n_value;
        end
    end

`ifndef SYNTHESIS
    // The reduced angle always lies in [0, 2*pi).
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTEP] |-> (r_red[NSTEP] < MOD_U))
        else $error("reduced angle is not below 2*pi");

    // The folded angle magnitude never exceeds pi.
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SX] |-> (r_ax >= 32'sd0) && ($unsigned(r_ax) <= X_MAX))
        else $error("folded angle outside [-pi, pi]");

    // A held stage keeps its item while the stage after it is blocked.
    a_hold_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SP] && !w_rdy[SP]) |=> (r_vld[SP] && $stable(r_pd) && $stable(r_y4)))
        else $error("blocked stage lost or changed its item");

    // With the output register empty the input side is never stalled.
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the pipeline can advance");
`endif

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the parabolic sine and cosine approximation pipeline.
module tb;

    localparam int ANGLE_FRAC  = 16;
    localparam int RESULT_FRAC = 30;
    localparam int WORK_FRAC   = 28;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam longint COEF_B = 64'sd1367130551;
    localparam longint COEF_C = 64'sd435171170;
    localparam longint COEF_P = 64'sd241591910;

    // Pi times 2^(60 - drop), rounded to nearest.
    function automatic longint pi_at(int drop);
        return longint'((PI_Q60 + (64'd1 << (drop - 1))) >> drop);
    endfunction

    localparam longint PI_A      = pi_at(60 - ANGLE_FRAC);
    localparam longint TWO_PI_A  = pi_at(59 - ANGLE_FRAC);
    localparam longint HALF_PI_A = pi_at(61 - ANGLE_FRAC);

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_func = OP_SINE;
    logic signed [31:0] i_angle = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_value;

    int idle_pct = 18;

    // Folds the angle into [-pi, pi), forms the parabola and refines it.
    function automatic logic signed [31:0] approx_sincos(logic is_cos,
                                                         logic signed [31:0] angle);
        longint a, t, r, x, ax, bx, xx, cx, y, ay, yy, d, pd, res;
        a = angle;
        if (is_cos == OP_COSINE) a += HALF_PI_A;
        t = a + PI_A;
        r = t % TWO_PI_A;
        if (r < 0) r += TWO_PI_A;
        x = (r - PI_A) <<< (WORK_FRAC - ANGLE_FRAC);
        ax = (x < 0) ? -x : x;
        bx = (COEF_B * x) >>> 28;
        xx = (x * ax) >>> 28;
        cx = (COEF_C * xx) >>> 28;
        y = bx - cx;
        ay = (y < 0) ? -y : y;
        yy = (y * ay) >>> 30;
        d = yy - y;
        pd = (COEF_P * d) >>> 30;
        res = (pd + y) >>> (30 - RESULT_FRAC);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return res[31:0];
    endfunction

    class sincos_tracker;
        logic signed [31:0] pending_values[$];
        int mismatches = 0;

        function void note_angle(logic is_cos, logic signed [31:0] angle);
            pending_values.push_back(approx_sincos(is_cos, angle));
        endfunction

        function void check_value(logic signed [31:0] value);
            logic signed [31:0] want;
            if (pending_values.size() == 0) begin
                $error("value: expected nothing, actual %0d", value);
                mismatches++;
                return;
            end
            want = pending_values.pop_front();
            if (value !== want) begin
                $error("value: expected %0d, actual %0d", want, value);
                mismatches++;
            end
        endfunction
    endclass

    sincos_tracker tracker = new();

    sine_cosine_parabolic_approx #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC),
        .RESULT_FRAC_BITS(RESULT_FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_func (i_func),
        .i_angle(i_angle),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_value(o_value)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_value(o_value);
    end

    task automatic send_angle(logic is_cos, logic signed [31:0] angle);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= is_cos;
        i_angle <= angle;
        do @(posedge i_clk); while (o_stall);
        tracker.note_angle(is_cos, angle);
    endtask

    initial begin
        logic signed [31:0] corner_angles[12];
        logic signed [31:0] angle;
        int kind;
        int k;
        corner_angles = '{32'sd0, 32'sd1, -32'sd1, 32'(PI_A), -32'(PI_A), 32'(PI_A - 1),
                          32'(HALF_PI_A), -32'(HALF_PI_A), 32'(TWO_PI_A), -32'(TWO_PI_A),
                          32'h7FFF_FFFF, 32'h8000_0000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes and the folding boundaries, for both operations.
        foreach (corner_angles[n]) begin
            send_angle(OP_SINE, corner_angles[n]);
            send_angle(OP_COSINE, corner_angles[n]);
        end

        for (int n = 0; n < 1800; n++) begin
            // A long stretch with both sides running flat out.
            idle_pct = (n >= 700 && n < 1000) ? 0 : 18;
            kind = $urandom_range(99);
            if (kind < 35) begin
                angle = 32'($urandom_range(0, 32'(8 * PI_A))) - 32'(4 * PI_A);
            end else if (kind < 60) begin
                angle = $urandom;
            end else if (kind < 85) begin
                k = int'($urandom_range(0, 40)) - 20;
                angle = 32'(k * HALF_PI_A) + 32'($urandom_range(0, 16)) - 32'sd8;
            end else if ($urandom_range(1) == 0) begin
                angle = 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
            end else begin
                angle = 32'h8000_0000 + 32'($urandom_range(0, 1000));
            end
            send_angle(1'($urandom_range(1)), angle);
        end
        i_valid <= 1'b0;

        while (tracker.pending_values.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("sine_cosine_parabolic_approx: match");
        end else begin
            $display("sine_cosine_parabolic_approx: mismatch");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("sine_cosine_parabolic_approx: mismatch");
        $finish;
    end

endmodule
